// ===== rtl/mapc_pkg.sv =====
// mapc_pkg: shared types and constants for the moving average calibration core.
// Holds the calibration register map, the calibration set and the queue entry type.
// Depends on nothing; used by every module of the core.
`default_nettype none

package mapc_pkg;

    localparam int CODE_W      = 16;
    localparam int VAL_W       = 32;
    localparam int SEG_W       = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int FIFO_DEPTH  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CODE0,
        REG_CODE1,
        REG_CODE2,
        REG_CODE3,
        REG_VALUE0,
        REG_VALUE1,
        REG_VALUE2,
        REG_VALUE3
    } cfg_reg_t;

    localparam logic [SEG_W-1:0] SEG_LOW  = 2'd0;
    localparam logic [SEG_W-1:0] SEG_MID  = 2'd1;
    localparam logic [SEG_W-1:0] SEG_HIGH = 2'd2;

    typedef struct packed {
        logic [3:0][CODE_W-1:0] code;
        logic [3:0][VAL_W-1:0]  value;
    } cal_t;

    localparam cal_t CAL_RESET = '{
        code:  {16'd65535, 16'd43690, 16'd21845, 16'd0},
        value: {32'd65535, 32'd43690, 32'd21845, 32'd0}
    };

    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] mean;
    } mean_xfer_t;

endpackage

`default_nettype wire

// ===== rtl/mapc_front.sv =====
// mapc_front: sample intake, window ring, running sum and truncated mean.
// Divides the running sum by WINDOW with a reciprocal multiply and one correction.
// Depends on mapc_pkg; feeds the mean queue.
`default_nettype none

module mapc_front #(
    parameter int WINDOW = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic [mapc_pkg::CODE_W-1:0]  sample,
    output mapc_pkg::mean_xfer_t              q_wr,
    input  wire logic                         q_full
);

    localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W  = mapc_pkg::CODE_W + $clog2(WINDOW);
    localparam int PROD_W = SUM_W + 33;
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / WINDOW);

    typedef enum logic [2:0] {
        F_IDLE,
        F_SUM,
        F_MUL,
        F_EST,
        F_FIX,
        F_PUSH
    } front_state_t;

    front_state_t state_reg, state_next;
    logic [PTR_W-1:0] wr_pos_reg, wr_pos_next;
    logic             win_full_reg, win_full_next;
    logic [SUM_W-1:0] sum_reg, sum_next;

    logic [mapc_pkg::CODE_W-1:0] win_mem [WINDOW];
    logic [mapc_pkg::CODE_W-1:0] old_reg;
    logic [mapc_pkg::CODE_W-1:0] sample_reg;
    logic [PROD_W-1:0]           prod_reg;
    logic [mapc_pkg::CODE_W-1:0] est_reg;
    logic [SUM_W-1:0]            estw_reg;
    logic [mapc_pkg::CODE_W-1:0] mean_reg;

    logic                        accept;
    logic                        win_we;
    logic [SUM_W-1:0]            drop_val;
    logic [SUM_W-1:0]            rem;
    logic [mapc_pkg::CODE_W-1:0] mean_fix;

    assign full   = (state_reg != F_IDLE);
    assign accept = push && !full;
    assign win_we = (state_reg == F_SUM);

    assign q_wr.valid = (state_reg == F_PUSH);
    assign q_wr.mean  = mean_reg;

    assign drop_val = win_full_reg ? SUM_W'(old_reg) : '0;
    assign rem      = sum_reg - estw_reg;
    assign mean_fix = (rem >= SUM_W'(WINDOW)) ? (est_reg + 1'b1) : est_reg;

    always_comb
    begin
        state_next    = state_reg;
        wr_pos_next   = wr_pos_reg;
        win_full_next = win_full_reg;
        sum_next      = sum_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_SUM;
                end
            end
            F_SUM:
            begin
                sum_next = sum_reg - drop_val + SUM_W'(sample_reg);
                if (wr_pos_reg == PTR_W'(WINDOW - 1))
                begin
                    wr_pos_next   = '0;
                    win_full_next = 1'b1;
                end
                else
                begin
                    wr_pos_next = wr_pos_reg + 1'b1;
                end
                state_next = F_MUL;
            end
            F_MUL:  state_next = F_EST;
            F_EST:  state_next = F_FIX;
            F_FIX:  state_next = F_PUSH;
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_IDLE;
            wr_pos_reg   <= '0;
            win_full_reg <= 1'b0;
            sum_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            wr_pos_reg   <= wr_pos_next;
            win_full_reg <= win_full_next;
            sum_reg      <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_we)
        begin
            win_mem[wr_pos_reg] <= sample_reg;
        end
        old_reg <= win_mem[wr_pos_reg];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample;
        end
        if (state_reg == F_MUL)
        begin
            prod_reg <= PROD_W'(sum_reg) * PROD_W'(RECIP);
        end
        if (state_reg == F_EST)
        begin
            est_reg  <= prod_reg[32 +: mapc_pkg::CODE_W];
            estw_reg <= SUM_W'(prod_reg[32 +: mapc_pkg::CODE_W]) * SUM_W'(WINDOW);
        end
        if (state_reg == F_FIX)
        begin
            mean_reg <= mean_fix;
        end
    end

    a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(win_full_reg))
        else $error("window full flag dropped");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(wr_pos_reg) < WINDOW)
        else $error("write position beyond window");

endmodule

`default_nettype wire

// ===== rtl/mapc_fifo.sv =====
// mapc_fifo: short queue of mean codes between the front and back parts.
// Lets the front run ahead while the back is dividing.
// Depends on mapc_pkg.
`default_nettype none

module mapc_fifo (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire mapc_pkg::mean_xfer_t  wr,
    output logic                       full,
    output mapc_pkg::mean_xfer_t       head,
    input  wire logic                  pop
);

    localparam int PTR_W = $clog2(mapc_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(mapc_pkg::FIFO_DEPTH + 1);

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic [mapc_pkg::CODE_W-1:0] entry [mapc_pkg::FIFO_DEPTH];

    logic empty;
    logic do_push;
    logic do_pop;

    assign full       = (count_reg == CNT_W'(mapc_pkg::FIFO_DEPTH));
    assign empty      = (count_reg == '0);
    assign do_push    = wr.valid && !full;
    assign do_pop     = pop && !empty;
    assign head.valid = !empty;
    assign head.mean  = entry[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry[wr_ptr_reg] <= wr.mean;
        end
    end

    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.valid && full) |=> (wr.valid && $stable(wr.mean)))
        else $error("queue write dropped while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== rtl/mapc_back.sv =====
// mapc_back: segment choice, interpolation and clamping of one mean code.
// Uses a 16x32 multiplier and a radix-4 serial divider, then an output register.
// Depends on mapc_pkg; reads from the mean queue.
`default_nettype none

module mapc_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mapc_pkg::cal_t                cal,
    input  wire mapc_pkg::mean_xfer_t          head,
    output logic                               q_pop,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [mapc_pkg::CODE_W-1:0]        mean_code,
    output logic [mapc_pkg::VAL_W-1:0]         calibrated,
    output logic [mapc_pkg::SEG_W-1:0]         segment
);

    localparam int NUM_W     = mapc_pkg::CODE_W + mapc_pkg::VAL_W;
    localparam int DIV_STEPS = NUM_W / 2;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEL,
        ST_DIFF,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } back_state_t;

    back_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    logic [mapc_pkg::CODE_W-1:0] x_reg;
    logic [mapc_pkg::SEG_W-1:0]  seg_reg;
    logic [mapc_pkg::CODE_W-1:0] xa_reg, xb_reg;
    logic [mapc_pkg::VAL_W-1:0]  ya_reg, yb_reg;
    logic [mapc_pkg::CODE_W-1:0] dxm_reg;
    logic [mapc_pkg::VAL_W-1:0]  dym_reg;
    logic [mapc_pkg::CODE_W-1:0] div_reg;
    logic                        neg_reg;
    logic                        zero_reg;
    logic [NUM_W-1:0]            num_reg;
    logic [mapc_pkg::CODE_W-1:0] rem_reg;
    logic [mapc_pkg::CODE_W-1:0] mean_code_reg;
    logic [mapc_pkg::VAL_W-1:0]  calibrated_reg;
    logic [mapc_pkg::SEG_W-1:0]  segment_reg;

    logic [mapc_pkg::CODE_W:0]   dx, sp;
    logic [mapc_pkg::VAL_W:0]    dy;
    logic [mapc_pkg::CODE_W+1:0] t, d1, d2, d3;
    logic [1:0]                  digit;
    logic [mapc_pkg::CODE_W+1:0] t_rem;
    logic [NUM_W:0]              sum_pos;
    logic [mapc_pkg::VAL_W-1:0]  res;
    logic                        load_out;

    assign q_pop    = (state_reg == ST_IDLE) && head.valid;
    assign empty    = !out_valid_reg;
    assign load_out = (state_reg == ST_FIN) && (!out_valid_reg || pop);

    assign mean_code  = mean_code_reg;
    assign calibrated = calibrated_reg;
    assign segment    = segment_reg;

    assign dx = {1'b0, x_reg} - {1'b0, xa_reg};
    assign sp = {1'b0, xb_reg} - {1'b0, xa_reg};
    assign dy = {1'b0, yb_reg} - {1'b0, ya_reg};

    assign t  = {rem_reg, num_reg[NUM_W-1 -: 2]};
    assign d1 = {2'b00, div_reg};
    assign d2 = {1'b0, div_reg, 1'b0};
    assign d3 = d1 + d2;

    always_comb
    begin
        if (t >= d3)
        begin
            digit = 2'd3;
            t_rem = t - d3;
        end
        else if (t >= d2)
        begin
            digit = 2'd2;
            t_rem = t - d2;
        end
        else if (t >= d1)
        begin
            digit = 2'd1;
            t_rem = t - d1;
        end
        else
        begin
            digit = 2'd0;
            t_rem = t;
        end
    end

    assign sum_pos = {{(NUM_W + 1 - mapc_pkg::VAL_W){1'b0}}, ya_reg} + {1'b0, num_reg};

    always_comb
    begin
        if (zero_reg)
        begin
            res = ya_reg;
        end
        else if (neg_reg)
        begin
            if (num_reg > NUM_W'(ya_reg))
            begin
                res = '0;
            end
            else
            begin
                res = ya_reg - num_reg[mapc_pkg::VAL_W-1:0];
            end
        end
        else if (sum_pos[NUM_W:mapc_pkg::VAL_W] != '0)
        begin
            res = '1;
        end
        else
        begin
            res = sum_pos[mapc_pkg::VAL_W-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && pop)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = ST_SEL;
                end
            end
            ST_SEL:  state_next = ST_DIFF;
            ST_DIFF: state_next = ST_MUL;
            ST_MUL:
            begin
                cnt_next   = '0;
                state_next = zero_reg ? ST_FIN : ST_DIV;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                x_reg <= head.mean;
            end
            ST_SEL:
            begin
                if (x_reg <= cal.code[1])
                begin
                    seg_reg <= mapc_pkg::SEG_LOW;
                    xa_reg  <= cal.code[0];
                    xb_reg  <= cal.code[1];
                    ya_reg  <= cal.value[0];
                    yb_reg  <= cal.value[1];
                end
                else if (x_reg <= cal.code[2])
                begin
                    seg_reg <= mapc_pkg::SEG_MID;
                    xa_reg  <= cal.code[1];
                    xb_reg  <= cal.code[2];
                    ya_reg  <= cal.value[1];
                    yb_reg  <= cal.value[2];
                end
                else
                begin
                    seg_reg <= mapc_pkg::SEG_HIGH;
                    xa_reg  <= cal.code[2];
                    xb_reg  <= cal.code[3];
                    ya_reg  <= cal.value[2];
                    yb_reg  <= cal.value[3];
                end
            end
            ST_DIFF:
            begin
                dxm_reg  <= dx[mapc_pkg::CODE_W] ? mapc_pkg::CODE_W'(~dx + 1'b1)
                                                 : dx[mapc_pkg::CODE_W-1:0];
                dym_reg  <= dy[mapc_pkg::VAL_W] ? mapc_pkg::VAL_W'(~dy + 1'b1)
                                                : dy[mapc_pkg::VAL_W-1:0];
                div_reg  <= sp[mapc_pkg::CODE_W] ? mapc_pkg::CODE_W'(~sp + 1'b1)
                                                 : sp[mapc_pkg::CODE_W-1:0];
                neg_reg  <= dx[mapc_pkg::CODE_W] ^ dy[mapc_pkg::VAL_W] ^ sp[mapc_pkg::CODE_W];
                zero_reg <= (sp == '0);
            end
            ST_MUL:
            begin
                num_reg <= NUM_W'(dxm_reg) * NUM_W'(dym_reg);
                rem_reg <= '0;
            end
            ST_DIV:
            begin
                num_reg <= {num_reg[NUM_W-3:0], digit};
                rem_reg <= t_rem[mapc_pkg::CODE_W-1:0];
            end
            default:
            begin
            end
        endcase
        if (load_out)
        begin
            mean_code_reg  <= x_reg;
            calibrated_reg <= res;
            segment_reg    <= seg_reg;
        end
    end

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < div_reg))
        else $error("divider remainder not below divisor");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> !zero_reg)
        else $error("divide entered with zero span");

endmodule

`default_nettype wire

// ===== rtl/moving_average_piecewise_calibration_core.sv =====
// A sample passes the front states, the mean queue and the back states to the output;
// the 24-step radix-4 divider in the back part is skipped when the span is zero. The front
// takes a new sample once its mean is queued, so it runs ahead while the back divides.
// Reset clears control, the running sum and the queue, and loads the calibration defaults;
// the window ring is not cleared, its entries are read only after being written.
// Depends on mapc_pkg, mapc_front, mapc_fifo and mapc_back.
`default_nettype none

module moving_average_piecewise_calibration_core #(
    parameter int WINDOW = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic [mapc_pkg::CODE_W-1:0]       sample,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic [mapc_pkg::CODE_W-1:0]            mean_code,
    output logic [mapc_pkg::VAL_W-1:0]             calibrated,
    output logic [mapc_pkg::SEG_W-1:0]             segment,
    input  wire logic                              cfg_we,
    input  wire logic [mapc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mapc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    mapc_pkg::cal_t       cal_reg;
    mapc_pkg::mean_xfer_t q_wr;
    mapc_pkg::mean_xfer_t q_head;
    logic                 q_full;
    logic                 q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= mapc_pkg::CAL_RESET;
        end
        else if (cfg_we)
        begin
            case (mapc_pkg::cfg_reg_t'(cfg_index))
                mapc_pkg::REG_CODE0:  cal_reg.code[0]  <= cfg_data[mapc_pkg::CODE_W-1:0];
                mapc_pkg::REG_CODE1:  cal_reg.code[1]  <= cfg_data[mapc_pkg::CODE_W-1:0];
                mapc_pkg::REG_CODE2:  cal_reg.code[2]  <= cfg_data[mapc_pkg::CODE_W-1:0];
                mapc_pkg::REG_CODE3:  cal_reg.code[3]  <= cfg_data[mapc_pkg::CODE_W-1:0];
                mapc_pkg::REG_VALUE0: cal_reg.value[0] <= cfg_data[mapc_pkg::VAL_W-1:0];
                mapc_pkg::REG_VALUE1: cal_reg.value[1] <= cfg_data[mapc_pkg::VAL_W-1:0];
                mapc_pkg::REG_VALUE2: cal_reg.value[2] <= cfg_data[mapc_pkg::VAL_W-1:0];
                mapc_pkg::REG_VALUE3: cal_reg.value[3] <= cfg_data[mapc_pkg::VAL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    mapc_front #(
        .WINDOW (WINDOW)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .sample (sample),
        .q_wr   (q_wr),
        .q_full (q_full)
    );

    mapc_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .full  (q_full),
        .head  (q_head),
        .pop   (q_pop)
    );

    mapc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cal        (cal_reg),
        .head       (q_head),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .mean_code  (mean_code),
        .calibrated (calibrated),
        .segment    (segment)
    );

endmodule

`default_nettype wire
